// ===== src/ncp_pkg.sv =====
// Shared types and constants of the near-plane triangle clipper.
`timescale 1ns / 1ps
package ncp_pkg;

	localparam int NATTR       = 8;
	localparam int ATTR_Z      = 2;
	localparam int ATTR_COLOR0 = 5;
	localparam int QDEPTH      = 2;

	// x, y, z, u, v, red, green, blue; colors sit in the low 16 bits of a lane
	typedef logic [NATTR-1:0][31:0] vtx_t;

	localparam logic [1:0] NIN_NONE = 2'd0;
	localparam logic [1:0] NIN_ONE  = 2'd1;
	localparam logic [1:0] NIN_TWO  = 2'd2;
	localparam logic [1:0] NIN_ALL  = 2'd3;

	typedef struct packed {
		vtx_t [2:0] vtx;
		logic [1:0] nin;   // vertices in front of the plane
		logic [1:0] apex;  // lone front vertex (one in front) or lone behind (two in front)
	} tri_job_t;

	typedef enum logic [2:0] {
		SRC_V0,
		SRC_V1,
		SRC_V2,
		SRC_CUT_B,
		SRC_CUT_C
	} vsrc_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV,
		BK_MUL,
		BK_ADD,
		BK_EMIT
	} back_state_t;

	function automatic logic [1:0] next_slot(input logic [1:0] s);
		logic [1:0] r;
		case (s)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/ncp_if.sv =====
// Vertex input and clipped vertex output channel interfaces.
`timescale 1ns / 1ps
interface ncp_vtx_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] tex_u;
	logic signed [31:0] tex_v;
	logic        [15:0] red_in;
	logic        [15:0] green_in;
	logic        [15:0] blue_in;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, red_in, green_in,
		blue_in, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, red_in, green_in,
		blue_in, output ready);
endinterface

interface ncp_vtx_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_u;
	logic signed [31:0] out_v;
	logic        [15:0] out_red;
	logic        [15:0] out_green;
	logic        [15:0] out_blue;
	logic               tri_end;
	logic               run_end;

	modport source (output valid, out_x, out_y, out_z, out_u, out_v, out_red, out_green,
		out_blue, tri_end, run_end, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_u, out_v, out_red, out_green,
		out_blue, tri_end, run_end, output ready);
endinterface

// ===== src/ncp_front.sv =====
// Front end: gathers three vertices and classifies the triangle against the near plane.
`timescale 1ns / 1ps
module ncp_front
	import ncp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	ncp_vtx_in_if.sink         vin,
	input  logic signed [31:0] near_clip,
	output tri_job_t           job,
	output logic               job_valid,
	input  logic               job_ready
);

	vtx_t       slot_q [2];
	logic [1:0] cnt_q;
	vtx_t       cur;
	logic [2:0] front;
	logic [1:0] nin;
	logic [1:0] apex;
	logic       third;
	logic       accept;

	always_comb begin
		cur    = '0;
		cur[0] = vin.pos_x;
		cur[1] = vin.pos_y;
		cur[2] = vin.pos_z;
		cur[3] = vin.tex_u;
		cur[4] = vin.tex_v;
		cur[5] = {16'd0, vin.red_in};
		cur[6] = {16'd0, vin.green_in};
		cur[7] = {16'd0, vin.blue_in};
	end

	assign third = (cnt_q == 2'd2);

	always_comb begin
		job.vtx[0] = slot_q[0];
		job.vtx[1] = slot_q[1];
		job.vtx[2] = cur;
		for (int i = 0; i < 3; i++) begin
			front[i] = $signed(job.vtx[i][ATTR_Z]) >= near_clip;
		end
		nin = 2'(front[0]) + 2'(front[1]) + 2'(front[2]);
		apex = 2'd0;
		if (nin == NIN_ONE) begin
			apex = front[0] ? 2'd0 : (front[1] ? 2'd1 : 2'd2);
		end else if (nin == NIN_TWO) begin
			apex = !front[0] ? 2'd0 : (!front[1] ? 2'd1 : 2'd2);
		end
		job.nin  = nin;
		job.apex = apex;
	end

	// a triangle entirely behind the plane is dropped here
	assign job_valid = vin.valid && third && (nin != NIN_NONE);
	assign vin.ready = !third || job_ready;
	assign accept    = vin.valid && vin.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= third ? 2'd0 : cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !third) begin
			slot_q[cnt_q[0]] <= cur;
		end
	end

endmodule

// ===== src/ncp_fifo.sv =====
// Short triangle queue between the front end and the clipping back end.
`timescale 1ns / 1ps
module ncp_fifo
	import ncp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  tri_job_t wr_data,
	input  logic     wr_valid,
	output logic     wr_ready,
	output tri_job_t rd_data,
	output logic     rd_valid,
	input  logic     rd_pop
);

	localparam int PTR_W = $clog2(QDEPTH);

	tri_job_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W:0]       cnt_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = (cnt_q != (PTR_W+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/ncp_back.sv =====
// Back end: cuts edges at the near plane and emits the clipped vertex runs.
`timescale 1ns / 1ps
module ncp_back
	import ncp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tri_job_t           job,
	input  logic               job_valid,
	output logic               job_pop,
	input  logic signed [31:0] near_clip,
	ncp_vtx_out_if.source      vout
);

	localparam int TW    = FRAC_BITS + 1;
	localparam int PW    = FRAC_BITS + 35;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	back_state_t            state_q, state_d;
	logic                   sel_q;
	logic [2:0]             attr_q;
	logic [CNT_W-1:0]       bit_q;
	logic [33:0]            rem_q;
	logic [32:0]            ud_q;
	logic [TW-1:0]          quo_q;
	logic signed [PW-1:0]   prod_q;
	vtx_t                   cut_q [2];
	logic [2:0]             k_q;
	vtx_t                   out_vtx_q;
	logic                   out_valid_q;
	logic                   out_tri_end_q;
	logic                   out_run_end_q;

	logic [1:0]             slot_b, slot_c;
	vtx_t                   va, vb;
	logic signed [32:0]     za, zb, near_ext, num, den;
	logic [32:0]            un, ud;
	logic                   ge;
	logic [33:0]            nrem;
	logic signed [32:0]     ea, eb, diff, step, sum;
	logic signed [PW-1:0]   shifted;
	logic [31:0]            res;
	logic                   attr_last;
	logic                   div_last;
	logic [1:0]             p;
	logic                   tri2;
	logic                   emit_last;
	logic                   load;
	vsrc_t                  src;
	vtx_t                   evtx;

	function automatic logic signed [32:0] ext_attr(input logic [2:0] idx,
		input logic [31:0] w);
		logic signed [32:0] r;
		if (idx >= 3'(ATTR_COLOR0)) r = {17'd0, w[15:0]};
		else r = {w[31], w};
		return r;
	endfunction

	assign slot_b = next_slot(job.apex);
	assign slot_c = next_slot(slot_b);
	assign va     = job.vtx[job.apex];
	assign vb     = job.vtx[sel_q ? slot_c : slot_b];

	// t = |near - za| * 2^F / |zb - za|, one quotient bit per cycle
	always_comb begin
		za       = {va[ATTR_Z][31], va[ATTR_Z]};
		zb       = {vb[ATTR_Z][31], vb[ATTR_Z]};
		near_ext = {near_clip[31], near_clip};
		num      = near_ext - za;
		den      = zb - za;
		un       = num[32] ? 33'(-num) : 33'(num);
		ud       = den[32] ? 33'(-den) : 33'(den);
		ge       = rem_q >= {1'b0, ud_q};
		nrem     = ge ? rem_q - {1'b0, ud_q} : rem_q;
		div_last = (bit_q == CNT_W'(FRAC_BITS));
	end

	// attribute = a + floor((b - a) * t / 2^F); the z lane takes the near plane
	always_comb begin
		ea        = ext_attr(attr_q, va[attr_q]);
		eb        = ext_attr(attr_q, vb[attr_q]);
		diff      = eb - ea;
		shifted   = prod_q >>> FRAC_BITS;
		step      = shifted[32:0];
		sum       = ea + step;
		res       = (attr_q == 3'(ATTR_Z)) ? near_clip : sum[31:0];
		attr_last = (attr_q == 3'(NATTR - 1));
	end

	// pick the vertex for output position k
	always_comb begin
		tri2 = (k_q >= 3'd3);
		p    = tri2 ? 2'(k_q - 3'd3) : k_q[1:0];
		src  = vsrc_t'({1'b0, p});
		case (job.nin)
			NIN_ONE: begin
				if (p == slot_b) src = SRC_CUT_B;
				else if (p == slot_c) src = SRC_CUT_C;
			end
			NIN_TWO: begin
				if (p == job.apex) src = tri2 ? SRC_CUT_C : SRC_CUT_B;
				else if (tri2 && p == slot_b) src = SRC_CUT_B;
			end
			default: ;
		endcase
		case (src)
			SRC_V0: evtx = job.vtx[0];
			SRC_V1: evtx = job.vtx[1];
			SRC_V2: evtx = job.vtx[2];
			SRC_CUT_B: evtx = cut_q[0];
			SRC_CUT_C: evtx = cut_q[1];
			default: evtx = job.vtx[0];
		endcase
		emit_last = (k_q == ((job.nin == NIN_TWO) ? 3'd5 : 3'd2));
	end

	assign load    = !out_valid_q || vout.ready;
	assign job_pop = (state_q == BK_EMIT) && load && emit_last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) state_d = (job.nin == NIN_ALL) ? BK_EMIT : BK_LOAD;
			end
			BK_LOAD: state_d = BK_DIV;
			BK_DIV: begin
				if (div_last) state_d = BK_MUL;
			end
			BK_MUL: state_d = BK_ADD;
			BK_ADD: begin
				if (!attr_last) state_d = BK_MUL;
				else state_d = sel_q ? BK_EMIT : BK_LOAD;
			end
			BK_EMIT: begin
				if (load && emit_last) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			sel_q       <= 1'b0;
			attr_q      <= '0;
			bit_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE: begin
					sel_q <= 1'b0;
					k_q   <= '0;
				end
				BK_LOAD: begin
					bit_q  <= '0;
					attr_q <= '0;
				end
				BK_DIV: begin
					bit_q <= bit_q + 1'b1;
				end
				BK_ADD: begin
					attr_q <= attr_q + 1'b1;
					if (attr_last) sel_q <= 1'b1;
				end
				BK_EMIT: begin
					if (load) k_q <= k_q + 3'd1;
				end
				default: ;
			endcase
			if (state_q == BK_EMIT && load) out_valid_q <= 1'b1;
			else if (vout.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_LOAD: begin
				rem_q <= {1'b0, un};
				ud_q  <= ud;
				quo_q <= '0;
			end
			BK_DIV: begin
				rem_q <= {nrem[32:0], 1'b0};
				quo_q <= {quo_q[TW-2:0], ge};
			end
			BK_MUL: prod_q <= diff * $signed({1'b0, quo_q});
			BK_ADD: cut_q[sel_q][attr_q] <= res;
			default: ;
		endcase
		if (state_q == BK_EMIT && load) begin
			out_vtx_q     <= evtx;
			out_tri_end_q <= (p == 2'd2);
			out_run_end_q <= emit_last;
		end
	end

	assign vout.valid     = out_valid_q;
	assign vout.out_x     = out_vtx_q[0];
	assign vout.out_y     = out_vtx_q[1];
	assign vout.out_z     = out_vtx_q[2];
	assign vout.out_u     = out_vtx_q[3];
	assign vout.out_v     = out_vtx_q[4];
	assign vout.out_red   = out_vtx_q[5][15:0];
	assign vout.out_green = out_vtx_q[6][15:0];
	assign vout.out_blue  = out_vtx_q[7][15:0];
	assign vout.tri_end   = out_tri_end_q;
	assign vout.run_end   = out_run_end_q;

endmodule

// ===== src/near_plane_triangle_clipper.sv =====
// Top level of the near-plane triangle clipper.
//
// vin takes one camera-space vertex per transaction (position, texture
// coordinates, color); every third vertex closes a triangle. vout gives the
// clipped vertices: 0, 3 or 6 per triangle, tri_end on the third vertex of each
// output triangle and run_end on the last one of the run. wr_en/wr_data write
// the near plane z (signed Q16.16, reset 1.0); write it only while idle.
// vin is always ready for the first two vertices of a triangle. A closed
// triangle goes into a two-entry queue; the back end then works on one
// triangle at a time. An unclipped triangle goes straight to emission. Each
// cut edge has a load step, then a restoring divider producing one bit of t
// per cycle, then one shared multiplier doing a multiply and an add for each
// of the eight attributes. A clipped triangle needs two cuts before its
// vertices are emitted. Reset clears the vertex count, queue and output valid.
// When vout stalls the output register holds; the queue keeps taking
// triangles until full, then vin deasserts ready on a closing vertex.
`timescale 1ns / 1ps
module near_plane_triangle_clipper
	import ncp_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [31:0] wr_data,
	ncp_vtx_in_if.sink     vin,
	ncp_vtx_out_if.source  vout
);

	logic signed [31:0] near_q;
	tri_job_t           fr_job;
	logic               fr_valid;
	logic               fr_ready;
	tri_job_t           bk_job;
	logic               bk_valid;
	logic               bk_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 32'sd65536;
		end else if (wr_en) begin
			near_q <= $signed(wr_data);
		end
	end

	ncp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vin       (vin),
		.near_clip (near_q),
		.job       (fr_job),
		.job_valid (fr_valid),
		.job_ready (fr_ready)
	);

	ncp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (fr_job),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.rd_data  (bk_job),
		.rd_valid (bk_valid),
		.rd_pop   (bk_pop)
	);

	ncp_back #(
		.FRAC_BITS (COORD_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (bk_job),
		.job_valid (bk_valid),
		.job_pop   (bk_pop),
		.near_clip (near_q),
		.vout      (vout)
	);

endmodule

// ===== src/ncp_checker.sv =====
// Port-level checks on the clipper output channel, bound to the top level.
`timescale 1ns / 1ps
module ncp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_x,
	input logic [31:0] out_z,
	input logic        tri_end,
	input logic        run_end
);

	// stalled transaction must hold
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_z)
			&& $stable(tri_end) && $stable(run_end))
		else $error("output payload changed while stalled");

	// a run always closes a whole triangle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_end |-> tri_end)
		else $error("run ended inside a triangle");

	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind near_plane_triangle_clipper ncp_checker u_ncp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (vout.valid),
	.out_ready (vout.ready),
	.out_x     (vout.out_x),
	.out_z     (vout.out_z),
	.tri_end   (vout.tri_end),
	.run_end   (vout.run_end)
);

// ===== sim/near_plane_triangle_clipper_tb.sv =====
// Self-checking testbench of the near-plane triangle clipper.
`timescale 1ns / 1ps
module near_plane_triangle_clipper_tb;
	import ncp_pkg::*;

	localparam int  FRAC        = 16;
	localparam int  DRAIN_WAIT  = 300;
	localparam int  CYCLE_LIMIT = 300000;
	localparam int  TRIS_PER_PH = 20;
	localparam int  NUM_DIR     = 6;
	localparam logic [31:0] NEAR_RESET = 32'h0001_0000;

	typedef struct packed {
		logic signed [31:0] x, y, z, u, v;
		logic [15:0]        r, g, b;
	} vertex_in_t;

	typedef struct packed {
		logic [7:0][31:0] lane;
		logic             tri_end;
		logic             run_end;
	} clip_vertex_t;

	typedef logic [7:0][63:0] attr_vec_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [31:0] wr_data;

	ncp_vtx_in_if  vin();
	ncp_vtx_out_if vout();

	near_plane_triangle_clipper u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.vin     (vin),
		.vout    (vout)
	);

	logic signed [31:0] near_z;
	attr_vec_t          tri_store [3];
	int                 slot_count;
	clip_vertex_t       clip_q [$];
	int                 tri_count_q [$];
	int                 errors;
	int                 hold_cycles;
	bit                 quiet;
	longint             cycles;

	vertex_in_t dir_tab [NUM_DIR*3];
	int         dir_cnt [NUM_DIR];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic attr_vec_t cut_edge(input attr_vec_t va, input attr_vec_t vb);
		attr_vec_t r;
		longint    num, den, un, ud, t, p;
		num = longint'(near_z) - $signed(va[2]);
		den = $signed(vb[2]) - $signed(va[2]);
		un  = (num < 0) ? -num : num;
		ud  = (den < 0) ? -den : den;
		t   = (ud != 0) ? (un <<< FRAC) / ud : 0;
		for (int i = 0; i < 8; i++) begin
			p    = ($signed(vb[i]) - $signed(va[i])) * t;
			r[i] = $signed(va[i]) + (p >>> FRAC);
		end
		r[2] = longint'(near_z);
		return r;
	endfunction

	function automatic void push_vertex(input attr_vec_t v, input bit te);
		clip_vertex_t c;
		for (int i = 0; i < 8; i++)
			c.lane[i] = (i >= ATTR_COLOR0) ? {16'h0, v[i][15:0]} : v[i][31:0];
		c.tri_end = te;
		c.run_end = 1'b0;
		clip_q.push_back(c);
	endfunction

	function automatic void push_tri(input attr_vec_t t0, t1, t2);
		push_vertex(t0, 1'b0);
		push_vertex(t1, 1'b0);
		push_vertex(t2, 1'b1);
	endfunction

	// Returns the number of clipped vertices the closed triangle produces.
	function automatic int clip_triangle();
		attr_vec_t v [3];
		attr_vec_t p_ab, p_ac;
		bit        front [3];
		int        nin, a, b, c, n0;
		nin = 0;
		a   = 0;
		n0  = clip_q.size();
		for (int i = 0; i < 3; i++) begin
			v[i]     = tri_store[i];
			front[i] = $signed(v[i][2]) >= longint'(near_z);
			if (front[i])
				nin++;
		end
		if (nin == 0)
			return 0;
		if (nin == 3) begin
			push_tri(v[0], v[1], v[2]);
		end else if (nin == 1) begin
			for (int i = 2; i >= 0; i--)
				if (front[i])
					a = i;
			b = (a + 1) % 3;
			c = (a + 2) % 3;
			p_ab = cut_edge(v[a], v[b]);
			p_ac = cut_edge(v[a], v[c]);
			v[b] = p_ab;
			v[c] = p_ac;
			push_tri(v[0], v[1], v[2]);
		end else begin
			for (int i = 2; i >= 0; i--)
				if (!front[i])
					a = i;
			b = (a + 1) % 3;
			c = (a + 2) % 3;
			p_ab = cut_edge(v[a], v[b]);
			p_ac = cut_edge(v[a], v[c]);
			v[a] = p_ab;
			push_tri(v[0], v[1], v[2]);
			v[a] = p_ac;
			v[b] = p_ab;
			push_tri(v[0], v[1], v[2]);
		end
		clip_q[clip_q.size()-1].run_end = 1'b1;
		return clip_q.size() - n0;
	endfunction

	// Track every accepted vertex transaction.
	always @(posedge clk) begin
		int n;
		if (arst_n && vin.valid && vin.ready) begin
			tri_store[slot_count][0] = longint'(vin.pos_x);
			tri_store[slot_count][1] = longint'(vin.pos_y);
			tri_store[slot_count][2] = longint'(vin.pos_z);
			tri_store[slot_count][3] = longint'(vin.tex_u);
			tri_store[slot_count][4] = longint'(vin.tex_v);
			tri_store[slot_count][5] = 64'(vin.red_in);
			tri_store[slot_count][6] = 64'(vin.green_in);
			tri_store[slot_count][7] = 64'(vin.blue_in);
			if (slot_count < 2) begin
				slot_count++;
			end else begin
				slot_count = 0;
				n = clip_triangle();
				if (tri_count_q.size() > 0) begin
					if (tri_count_q[0] != n)
						report($sformatf("directed triangle gave %0d vertices, want %0d",
							n, tri_count_q[0]));
					void'(tri_count_q.pop_front());
				end
			end
		end
	end

	// Compare each clipped vertex transaction with the oldest expectation.
	always @(posedge clk) begin
		clip_vertex_t got, want;
		if (arst_n && vout.valid && vout.ready) begin
			got.lane    = {{16'h0, vout.out_blue}, {16'h0, vout.out_green},
				{16'h0, vout.out_red}, vout.out_v, vout.out_u, vout.out_z, vout.out_y,
				vout.out_x};
			got.tri_end = vout.tri_end;
			got.run_end = vout.run_end;
			if (clip_q.size() == 0) begin
				report("clipped vertex with nothing expected");
			end else begin
				want = clip_q.pop_front();
				for (int i = 0; i < 8; i++)
					if (got.lane[i] !== want.lane[i])
						report($sformatf("attr %0d got %h want %h", i, got.lane[i],
							want.lane[i]));
				if (got.tri_end !== want.tri_end)
					report($sformatf("tri_end got %b want %b", got.tri_end, want.tri_end));
				if (got.run_end !== want.run_end)
					report($sformatf("run_end got %b want %b", got.run_end, want.run_end));
			end
		end
	end

	// Output side: long hold-off when asked, else random stall bursts unless quiet.
	always @(negedge clk) begin
		int burst;
		if (hold_cycles > 0) begin
			hold_cycles--;
			vout.ready = 1'b0;
		end else if (burst > 0) begin
			burst--;
			vout.ready = 1'b0;
		end else if (!quiet && $urandom_range(5) == 0) begin
			burst      = $urandom_range(3);
			vout.ready = 1'b0;
		end else begin
			vout.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_vertex(input vertex_in_t d);
		int gap;
		if (!quiet && $urandom_range(4) == 0) begin
			gap = $urandom_range(1, 4);
			vin.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		vin.valid    = 1'b1;
		vin.pos_x    = d.x;
		vin.pos_y    = d.y;
		vin.pos_z    = d.z;
		vin.tex_u    = d.u;
		vin.tex_v    = d.v;
		vin.red_in   = d.r;
		vin.green_in = d.g;
		vin.blue_in  = d.b;
		do
			@(posedge clk);
		while (!vin.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		vin.valid = 1'b0;
		while (clip_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_near(input logic [31:0] val);
		wr_en   = 1'b1;
		wr_data = val;
		@(negedge clk);
		wr_en  = 1'b0;
		near_z = val;
	endtask

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(65535 * 8)) - 65536 * 4;
			2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $signed($urandom) >>> $urandom_range(8, 20);
		endcase
	endfunction

	// Keep most depths near the plane so that cuts are common.
	function automatic vertex_in_t random_vertex();
		vertex_in_t d;
		longint     z;
		d.x = pick_coord();
		d.y = pick_coord();
		d.u = pick_coord();
		d.v = pick_coord();
		if ($urandom_range(4) == 0) begin
			d.z = pick_coord();
		end else begin
			z = longint'(near_z) + $signed($urandom_range(1 << 21)) - (1 << 20);
			if (z > 64'sh7fff_ffff)
				z = 64'sh7fff_ffff;
			if (z < -64'sh8000_0000)
				z = -64'sh8000_0000;
			d.z = z[31:0];
		end
		d.r = $urandom;
		d.g = $urandom;
		d.b = $urandom;
		return d;
	endfunction

	task automatic random_triangles(input int n);
		repeat (n)
			for (int k = 0; k < 3; k++)
				send_vertex(random_vertex());
	endtask

	initial begin
		logic [31:0] plane [6];
		dir_tab = '{
			// all in front, one exactly on the plane
			'{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0002_0000, 32'sh8000_0000, 32'sh7fff_ffff,
				16'hffff, 16'h0000, 16'hffff},
			'{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
				16'h0000, 16'hffff, 16'h0000},
			'{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0, 16'h1, 16'h2, 16'h3},
			// all behind: drop
			'{32'sh1, 32'sh2, 32'sh8000_0000, 32'sh3, 32'sh4, 16'h5, 16'h6, 16'h7},
			'{32'sh1, 32'sh2, 32'sh0, 32'sh3, 32'sh4, 16'h5, 16'h6, 16'h7},
			'{32'sh1, 32'sh2, 32'sh0000_ffff, 32'sh3, 32'sh4, 16'h5, 16'h6, 16'h7},
			// one in front at slot 0, depth extremes
			'{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
				16'hffff, 16'hffff, 16'hffff},
			'{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
				16'h0000, 16'h0000, 16'h0000},
			'{32'sh0010_0000, 32'shfff0_0000, 32'shfffe_0000, 32'sh0, 32'sh0001_0000,
				16'h8000, 16'h1234, 16'hffff},
			// one in front at slot 2
			'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'h0, 16'h0, 16'h0},
			'{32'sh0004_0000, 32'sh0, 32'sh0, 32'sh0004_0000, 32'sh0, 16'hffff, 16'h0, 16'h0},
			'{32'sh0, 32'sh0004_0000, 32'sh0003_0000, 32'sh0, 32'sh0004_0000,
				16'h0, 16'hffff, 16'h0},
			// two in front, slot 1 behind
			'{32'shffff_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0, 32'sh0,
				16'h0100, 16'h0200, 16'h0300},
			'{32'sh0005_0000, 32'shfffb_0000, 32'shffff_0000, 32'sh0001_0000, 32'sh0002_0000,
				16'hff00, 16'h00ff, 16'h0f0f},
			'{32'sh0, 32'sh0, 32'sh0005_0000, 32'shffff_8000, 32'sh0000_8000,
				16'h0001, 16'hfffe, 16'h7fff},
			// two in front, slot 0 behind at the most negative depth
			'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
				16'h0000, 16'h0000, 16'h0000},
			'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
				16'hffff, 16'hffff, 16'hffff},
			'{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0, 16'h0, 16'h0, 16'h0}
		};
		dir_cnt = '{3, 0, 3, 3, 6, 6};
		plane   = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hfffb_0000,
			$urandom, NEAR_RESET};

		errors       = 0;
		cycles       = 0;
		slot_count   = 0;
		hold_cycles  = 0;
		quiet        = 1'b0;
		near_z       = NEAR_RESET;
		wr_en        = 1'b0;
		wr_data      = '0;
		vin.valid    = 1'b0;
		vin.pos_x    = '0;
		vin.pos_y    = '0;
		vin.pos_z    = '0;
		vin.tex_u    = '0;
		vin.tex_v    = '0;
		vin.red_in   = '0;
		vin.green_in = '0;
		vin.blue_in  = '0;
		vout.ready   = 1'b0;
		arst_n       = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int t = 0; t < NUM_DIR; t++)
			tri_count_q.push_back(dir_cnt[t]);
		foreach (dir_tab[i])
			send_vertex(dir_tab[i]);
		random_triangles(TRIS_PER_PH);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_near(plane[ph]);
			// back up the output so the queue fills and vin stalls
			if (ph == 3)
				hold_cycles = 600;
			if (ph == 5)
				quiet = 1'b1;
			random_triangles(TRIS_PER_PH);
		end

		vin.valid = 1'b0;
		while (clip_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
